// ===== hdl/motion_activity_classifier_defines.svh =====
// Assertion macros shared by the motion activity classifier RTL.
`ifndef MOTION_ACTIVITY_CLASSIFIER_DEFINES_SVH
`define MOTION_ACTIVITY_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define MAC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("motion activity classifier check failed");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define MAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("motion activity classifier check failed");
`else
`define MAC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define MAC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/mac_pkg.sv =====
// Shared types and constants of the motion activity classifier.
package mac_pkg;

    localparam int THRESH_W = 26;
    localparam int BYTE_W   = 8;

    localparam logic [BYTE_W-1:0] COUNT_MAX = 8'hFF;

    // Record byte is (magnitude / RECORD_DIV) mod 256.
    localparam int RECORD_DIV   = 10000;
    localparam int RECORD_SHIFT = 14;   // ceil(log2(RECORD_DIV))

    // Register indexes; register i sits at byte address 4*i.
    localparam logic [1:0] REG_WALK       = 2'd0;
    localparam logic [1:0] REG_RUN        = 2'd1;
    localparam logic [1:0] REG_DECIMATION = 2'd2;
    localparam logic [1:0] REG_RUN_LIMIT  = 2'd3;

    typedef enum logic [1:0] {
        ACT_STANDING = 2'd0,
        ACT_WALKING  = 2'd1,
        ACT_RUNNING  = 2'd2
    } t_activity;

    typedef enum logic [1:0] {
        EVT_NONE   = 2'd0,
        EVT_RAISE  = 2'd1,
        EVT_CANCEL = 2'd2
    } t_alarm_event;

    typedef struct packed {
        logic [THRESH_W-1:0] walk_threshold;
        logic [THRESH_W-1:0] run_threshold;
        logic [BYTE_W-1:0]   decimation;
        logic [BYTE_W-1:0]   run_limit;
    } t_class_cfg;

    typedef struct packed {
        logic              class_valid;
        t_activity         activity;
        t_alarm_event      alarm_event;
        logic              record_valid;
        logic [BYTE_W-1:0] record_byte;
    } t_result;

endpackage

// ===== hdl/mac_lane.sv =====
// One axis lane: registered square of a signed acceleration sample.
module mac_lane #(
    parameter int SAMPLE_BITS = 13
) (
    input  logic                     i_clk,
    input  logic                     i_load,
    input  logic [SAMPLE_BITS-1:0]   i_sample,
    output logic [2*SAMPLE_BITS-2:0] o_square
);

    logic signed [SAMPLE_BITS-1:0]   w_sample;
    logic signed [2*SAMPLE_BITS-1:0] w_prod;
    logic        [2*SAMPLE_BITS-2:0] r_square;

    assign w_sample = $signed(i_sample);
    assign w_prod   = w_sample * w_sample;

    // The square is never negative and at most 2**(2*SAMPLE_BITS-2).
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_square <= w_prod[2*SAMPLE_BITS-2:0];
        end
    end

    assign o_square = r_square;

endmodule

// ===== hdl/mac_filter.sv =====
// Smoothing filter stage and record-byte quotient of the magnitude.
module mac_filter #(
    parameter int MAG_W   = 26,
    parameter int IIR_DIV = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic [MAG_W-1:0]  i_mag,
    output logic [MAG_W-1:0]  o_avg,
    output logic [7:0]        o_rec_byte
);
    import mac_pkg::*;

    localparam int K    = $clog2(IIR_DIV);
    localparam bit POW2 = (IIR_DIV == (1 << K));
    localparam int S    = MAG_W + K;
    localparam int M_W  = MAG_W + 2;
    localparam logic [63:0] M_FULL = ((64'd1 << S) + 64'(IIR_DIV) - 64'd1) / 64'(IIR_DIV);

    localparam int RS    = MAG_W + RECORD_SHIFT;
    localparam int RM_W  = MAG_W + 2;
    localparam logic [63:0] RM_FULL =
        ((64'd1 << RS) + 64'(RECORD_DIV) - 64'd1) / 64'(RECORD_DIV);
    localparam int P_W   = (2 * MAG_W + 2 > RS + 8) ? 2 * MAG_W + 2 : RS + 8;

    logic [MAG_W-1:0] r_avg;
    logic [MAG_W-1:0] n_avg;
    logic [7:0]       r_rec_byte;
    logic [MAG_W:0]   w_diff;
    logic             w_neg;
    logic [MAG_W:0]   w_abs_full;
    logic [MAG_W-1:0] w_abs;
    logic [MAG_W-1:0] w_q;
    logic [P_W-1:0]   w_rprod;

    // Difference is signed; the quotient truncates toward zero.
    assign w_diff     = {1'b0, i_mag} - {1'b0, r_avg};
    assign w_neg      = w_diff[MAG_W];
    assign w_abs_full = w_neg ? (~w_diff + 1'b1) : w_diff;
    assign w_abs      = w_abs_full[MAG_W-1:0];

    generate
        if (POW2) begin : g_shift
            assign w_q = w_abs >> K;
        end else begin : g_recip
            logic [MAG_W+M_W-1:0] w_prod;
            logic [MAG_W+M_W-1:0] w_shifted;
            assign w_prod    = {{M_W{1'b0}}, w_abs} * {{MAG_W{1'b0}}, M_FULL[M_W-1:0]};
            assign w_shifted = w_prod >> S;
            assign w_q       = w_shifted[MAG_W-1:0];
        end
    endgenerate

    assign n_avg = w_neg ? (r_avg - w_q) : (r_avg + w_q);

    assign w_rprod = P_W'({{RM_W{1'b0}}, i_mag} * {{MAG_W{1'b0}}, RM_FULL[RM_W-1:0]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg <= '0;
        end else if (i_load) begin
            r_avg <= n_avg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rec_byte <= w_rprod[RS +: 8];
        end
    end

    assign o_avg      = r_avg;
    assign o_rec_byte = r_rec_byte;

endmodule

// ===== hdl/mac_classify.sv =====
// Decimated classification, run counter, alarm tracking and result register.
module mac_classify #(
    parameter int MAG_W = 26
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  logic [MAG_W-1:0]     i_avg,
    input  logic [7:0]           i_rec_byte,
    input  mac_pkg::t_class_cfg  i_cfg,
    output mac_pkg::t_result     o_result
);
    import mac_pkg::*;

    localparam int CMP_W = (MAG_W > THRESH_W) ? MAG_W : THRESH_W;

    logic [BYTE_W-1:0] r_phase;
    logic [BYTE_W-1:0] n_phase;
    logic [BYTE_W-1:0] r_count;
    logic [BYTE_W-1:0] n_count;
    logic              r_alarm;
    logic              n_alarm;
    t_result           r_result;
    t_result           n_result;

    logic [BYTE_W-1:0] w_dec;
    logic [BYTE_W-1:0] w_lim;
    logic [BYTE_W:0]   w_phase_inc;
    logic [CMP_W-1:0]  w_avg;
    logic              w_below_walk;
    logic              w_below_run;
    logic              w_classify;

    assign w_dec = (i_cfg.decimation == '0) ? BYTE_W'(1) : i_cfg.decimation;
    assign w_lim = (i_cfg.run_limit == '0) ? BYTE_W'(1) : i_cfg.run_limit;

    assign w_avg        = CMP_W'(i_avg);
    assign w_below_walk = w_avg < CMP_W'(i_cfg.walk_threshold);
    assign w_below_run  = w_avg < CMP_W'(i_cfg.run_threshold);
    assign w_classify   = (r_phase == '0);

    assign w_phase_inc = {1'b0, r_phase} + 1'b1;
    assign n_phase     = (w_phase_inc >= {1'b0, w_dec}) ? '0 : w_phase_inc[BYTE_W-1:0];

    always_comb begin
        n_count              = r_count;
        n_alarm              = r_alarm;
        n_result.class_valid = w_classify;
        n_result.activity    = ACT_STANDING;
        n_result.alarm_event = EVT_NONE;
        if (w_classify) begin
            if (w_below_walk || w_below_run) begin
                n_result.activity = w_below_walk ? ACT_STANDING : ACT_WALKING;
                n_count           = '0;
                if (r_alarm) begin
                    n_alarm              = 1'b0;
                    n_result.alarm_event = EVT_CANCEL;
                end
            end else begin
                n_result.activity = ACT_RUNNING;
                if (r_count != COUNT_MAX) begin
                    n_count = r_count + 1'b1;
                end
            end
            if (n_count >= w_lim && !n_alarm) begin
                n_alarm              = 1'b1;
                n_result.alarm_event = EVT_RAISE;
            end
        end
        n_result.record_valid = n_alarm;
        n_result.record_byte  = n_alarm ? i_rec_byte : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_count <= '0;
            r_alarm <= 1'b0;
        end else if (i_load) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_alarm <= n_alarm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

// ===== hdl/motion_activity_classifier.sv =====
// Top level of the motion activity classifier: lanes, merge, filter, classifier, registers.
//
// One word on the input channel carries a three-axis acceleration sample
// (i_accel_x, i_accel_y, i_accel_z, two's complement). Every accepted word
// yields exactly one result word on the output channel: a classification
// flag with its activity class, an alarm event and an optional record byte.
// The path is a four-stage pipeline: three lanes square the axes, a merge
// stage sums them into the squared magnitude, the filter stage updates the
// smoothed magnitude and forms magnitude / 10000, and the classifier stage
// registers the result word. One word can be accepted in every cycle while
// the output is not stalled. That rate is set by the filter recurrence,
// whose divide (a shift for a power-of-two IIR_DIV) and add are combinational.
// Each stage holds its word while the one ahead is full and stalled, so a
// stalled receiver fills the pipeline one stage at a time; o_in_ready drops
// only once all four stages hold words. Words are never dropped or repeated.
// Synchronous reset empties the pipeline, clears the smoothed magnitude,
// sample phase, run counter and alarm, and loads the register defaults.
// The register port is APB-style with pready tied high; registers must be
// written only while the pipeline is empty.
`include "motion_activity_classifier_defines.svh"

module motion_activity_classifier #(
    parameter int IIR_DIV     = 8,
    parameter int SAMPLE_BITS = 13
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [SAMPLE_BITS-1:0] i_accel_x,
    input  logic [SAMPLE_BITS-1:0] i_accel_y,
    input  logic [SAMPLE_BITS-1:0] i_accel_z,

    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_class_valid,
    output logic [1:0]             o_activity,
    output logic [1:0]             o_alarm_event,
    output logic                   o_record_valid,
    output logic [7:0]             o_record_byte,

    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [3:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import mac_pkg::*;

    localparam int MAG_W   = 2 * SAMPLE_BITS;
    localparam int SQ_W    = 2 * SAMPLE_BITS - 1;
    localparam int N_LANES = 3;

    localparam logic [THRESH_W-1:0] WALK_RESET  = THRESH_W'(1000000);
    localparam logic [THRESH_W-1:0] RUN_RESET   = THRESH_W'(4000000);
    localparam logic [BYTE_W-1:0]   DEC_RESET   = BYTE_W'(10);
    localparam logic [BYTE_W-1:0]   LIMIT_RESET = BYTE_W'(5);

    // ------------------------------------------------------------------
    // Configuration registers. A write lands in the access phase; the
    // register index is taken from byte address bits 3:2.
    // ------------------------------------------------------------------
    t_class_cfg r_cfg;
    logic       w_cfg_write;
    logic [1:0] w_cfg_index;

    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;
    assign w_cfg_index = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.walk_threshold <= WALK_RESET;
            r_cfg.run_threshold  <= RUN_RESET;
            r_cfg.decimation     <= DEC_RESET;
            r_cfg.run_limit      <= LIMIT_RESET;
        end else if (w_cfg_write) begin
            case (w_cfg_index)
                REG_WALK:       r_cfg.walk_threshold <= pwdata[THRESH_W-1:0];
                REG_RUN:        r_cfg.run_threshold  <= pwdata[THRESH_W-1:0];
                REG_DECIMATION: r_cfg.decimation     <= pwdata[BYTE_W-1:0];
                REG_RUN_LIMIT:  r_cfg.run_limit      <= pwdata[BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_cfg_index)
            REG_WALK:       prdata = 32'(r_cfg.walk_threshold);
            REG_RUN:        prdata = 32'(r_cfg.run_threshold);
            REG_DECIMATION: prdata = 32'(r_cfg.decimation);
            REG_RUN_LIMIT:  prdata = 32'(r_cfg.run_limit);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control. A stage advances when it is empty or when the
    // stage ahead advances; it loads a word when it advances and the
    // stage behind holds one.
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_adv1, w_adv2, w_adv3, w_adv4;
    logic w_load1, w_load2, w_load3, w_load4;

    assign w_adv4  = !r_v4 || i_out_ready;
    assign w_adv3  = !r_v3 || w_adv4;
    assign w_adv2  = !r_v2 || w_adv3;
    assign w_adv1  = !r_v1 || w_adv2;

    assign w_load1 = i_in_valid && w_adv1;
    assign w_load2 = r_v1 && w_adv2;
    assign w_load3 = r_v2 && w_adv3;
    assign w_load4 = r_v3 && w_adv4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_v1 <= i_in_valid;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
            if (w_adv3) begin
                r_v3 <= r_v2;
            end
            if (w_adv4) begin
                r_v4 <= r_v3;
            end
        end
    end

    assign o_in_ready  = w_adv1;
    assign o_out_valid = r_v4;

    // ------------------------------------------------------------------
    // Stage 1: one squaring lane per axis.
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] w_axis   [N_LANES];
    logic [SQ_W-1:0]        w_square [N_LANES];

    assign w_axis[0] = i_accel_x;
    assign w_axis[1] = i_accel_y;
    assign w_axis[2] = i_accel_z;

    generate
        for (genvar g = 0; g < N_LANES; g++) begin : g_lane
            mac_lane #(
                .SAMPLE_BITS (SAMPLE_BITS)
            ) u_lane (
                .i_clk    (i_clk),
                .i_load   (w_load1),
                .i_sample (w_axis[g]),
                .o_square (w_square[g])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Stage 2: merge the lanes into the squared magnitude. Three squares
    // of at most 2**(MAG_W-2) each always fit in MAG_W bits.
    // ------------------------------------------------------------------
    logic [MAG_W-1:0] r_mag;

    always_ff @(posedge i_clk) begin
        if (w_load2) begin
            r_mag <= MAG_W'(w_square[0]) + MAG_W'(w_square[1]) + MAG_W'(w_square[2]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: smoothing filter and record quotient.
    // ------------------------------------------------------------------
    logic [MAG_W-1:0] w_avg;
    logic [7:0]       w_rec_byte;

    mac_filter #(
        .MAG_W   (MAG_W),
        .IIR_DIV (IIR_DIV)
    ) u_filter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load3),
        .i_mag      (r_mag),
        .o_avg      (w_avg),
        .o_rec_byte (w_rec_byte)
    );

    // ------------------------------------------------------------------
    // Stage 4: classification and the result word register.
    // ------------------------------------------------------------------
    t_result w_result;

    mac_classify #(
        .MAG_W (MAG_W)
    ) u_classify (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load4),
        .i_avg      (w_avg),
        .i_rec_byte (w_rec_byte),
        .i_cfg      (r_cfg),
        .o_result   (w_result)
    );

    assign o_class_valid  = w_result.class_valid;
    assign o_activity     = w_result.activity;
    assign o_alarm_event  = w_result.alarm_event;
    assign o_record_valid = w_result.record_valid;
    assign o_record_byte  = w_result.record_byte;

    // ------------------------------------------------------------------
    // Checks on the result word and the pipeline fill.
    // ------------------------------------------------------------------
    `MAC_ASSERT_NOW(a_event_needs_class, i_clk, i_rst_n,
        o_out_valid && !o_class_valid, o_alarm_event == EVT_NONE)
    `MAC_ASSERT_NOW(a_raise_is_running, i_clk, i_rst_n,
        o_out_valid && o_alarm_event == EVT_RAISE,
        o_record_valid && o_activity == ACT_RUNNING)
    `MAC_ASSERT_NOW(a_cancel_not_running, i_clk, i_rst_n,
        o_out_valid && o_alarm_event == EVT_CANCEL,
        !o_record_valid && o_activity != ACT_RUNNING)
    `MAC_ASSERT_NOW(a_byte_needs_alarm, i_clk, i_rst_n,
        o_out_valid && !o_record_valid, o_record_byte == 8'd0)
    `MAC_ASSERT_NEXT(a_accept_fills_lane, i_clk, i_rst_n,
        i_in_valid && o_in_ready, r_v1)

endmodule

// ===== tb/motion_activity_classifier_tb.sv =====
// Self-checking testbench of the motion activity classifier: sample stream, registers, results.
module motion_activity_classifier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mac_pkg::*;

    localparam int SAMPLE_BITS  = 13;
    localparam int IIR_DIV      = 8;
    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 12;
    // Far above the slowest legal run of roughly 1000 samples under the heaviest stalls.
    localparam int CYCLE_LIMIT  = 200000;
    // Pipeline depth is four stages; the drain wait catches any stray word.
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_PRINTED  = 40;
    localparam int LONG_STALL   = 200;

    localparam logic [THRESH_W-1:0] THRESH_MAX = '1;
    localparam logic [SAMPLE_BITS-1:0] AXIS_MIN = 13'h1000;   // -4096
    localparam logic [SAMPLE_BITS-1:0] AXIS_MAX = 13'h0FFF;   // +4095

    // Motion levels used to build bursts of samples with a steady character.
    localparam int LVL_QUIET = 0;
    localparam int LVL_WALK  = 1;
    localparam int LVL_RUN   = 2;
    localparam int LVL_FULL  = 3;

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_in_valid     = 1'b0;
    logic                   o_in_ready;
    logic [SAMPLE_BITS-1:0] i_accel_x      = '0;
    logic [SAMPLE_BITS-1:0] i_accel_y      = '0;
    logic [SAMPLE_BITS-1:0] i_accel_z      = '0;
    logic                   o_out_valid;
    logic                   i_out_ready    = 1'b0;
    logic                   o_class_valid;
    logic [1:0]             o_activity;
    logic [1:0]             o_alarm_event;
    logic                   o_record_valid;
    logic [7:0]             o_record_byte;
    logic                   psel           = 1'b0;
    logic                   penable        = 1'b0;
    logic                   pwrite         = 1'b0;
    logic [3:0]             paddr          = '0;
    logic [31:0]            pwdata         = '0;
    logic [31:0]            prdata;
    logic                   pready;

    motion_activity_classifier #(
        .IIR_DIV     (IIR_DIV),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_accel_x      (i_accel_x),
        .i_accel_y      (i_accel_y),
        .i_accel_z      (i_accel_z),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_class_valid  (o_class_valid),
        .o_activity     (o_activity),
        .o_alarm_event  (o_alarm_event),
        .o_record_valid (o_record_valid),
        .o_record_byte  (o_record_byte),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // Idle percentages of the two channels and the length of a forced output stall.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_left    = 0;
    int cycle_count   = 0;
    int mismatch_count = 0;

    // Result words predicted for accepted samples, oldest first.
    t_result predicted_words[$];

    // Shadow copy of the registers and of the classifier state.
    t_class_cfg  cfg_shadow;
    logic [31:0] avg_shadow;
    int          phase_shadow;
    logic [7:0]  run_shadow;
    logic        alarm_shadow;

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // Output side. A requested long stall holds ready low until stall_left counts down to
    // zero; otherwise ready drops at random with the current idle percentage.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) begin
            $display("MISMATCH cycle %0d %s: got %0d expected %0d", cycle_count, field, got,
                     want);
        end
    endtask

    // Every word taken from the output is compared field by field with the oldest prediction.
    // Values are sampled right at the clock edge, before the block updates its outputs.
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (predicted_words.size() == 0) begin
                report_mismatch("word with nothing expected", 1, 0);
            end else begin
                want = predicted_words.pop_front();
                if (o_class_valid !== want.class_valid)
                    report_mismatch("class_valid", 32'(o_class_valid), 32'(want.class_valid));
                if (o_activity !== want.activity)
                    report_mismatch("activity", 32'(o_activity), 32'(want.activity));
                if (o_alarm_event !== want.alarm_event)
                    report_mismatch("alarm_event", 32'(o_alarm_event), 32'(want.alarm_event));
                if (o_record_valid !== want.record_valid)
                    report_mismatch("record_valid", 32'(o_record_valid),
                                    32'(want.record_valid));
                if (o_record_byte !== want.record_byte)
                    report_mismatch("record_byte", 32'(o_record_byte), 32'(want.record_byte));
            end
        end
    end

    // State after reset: register defaults, empty filter, phase zero, no alarm.
    task automatic reset_shadow();
        cfg_shadow.walk_threshold = 26'd1000000;
        cfg_shadow.run_threshold  = 26'd4000000;
        cfg_shadow.decimation     = 8'd10;
        cfg_shadow.run_limit      = 8'd5;
        avg_shadow   = '0;
        phase_shadow = 0;
        run_shadow   = '0;
        alarm_shadow = 1'b0;
    endtask

    // Predicts the result word of one sample and advances the shadow state.
    function automatic t_result classify_sample(input logic signed [SAMPLE_BITS-1:0] x,
                                                input logic signed [SAMPLE_BITS-1:0] y,
                                                input logic signed [SAMPLE_BITS-1:0] z);
        longint  mag;
        longint  avg;
        int      dec;
        int      lim;
        t_result r;
        mag = longint'(x) * longint'(x) + longint'(y) * longint'(y)
            + longint'(z) * longint'(z);
        // Signed division truncates toward zero, so a small negative step leaves avg alone.
        avg = longint'(avg_shadow);
        avg = avg + (mag - avg) / IIR_DIV;
        avg_shadow = avg[31:0];
        dec = (cfg_shadow.decimation == 0) ? 1 : int'(cfg_shadow.decimation);
        lim = (cfg_shadow.run_limit == 0) ? 1 : int'(cfg_shadow.run_limit);
        r = '0;
        if (phase_shadow == 0) begin
            r.class_valid = 1'b1;
            // Tested in this order even when the walk threshold is above the run threshold.
            if (avg < longint'(cfg_shadow.walk_threshold)
                    || avg < longint'(cfg_shadow.run_threshold)) begin
                r.activity = (avg < longint'(cfg_shadow.walk_threshold)) ? ACT_STANDING
                                                                          : ACT_WALKING;
                run_shadow = '0;
                if (alarm_shadow) begin
                    alarm_shadow  = 1'b0;
                    r.alarm_event = EVT_CANCEL;
                end
            end else begin
                r.activity = ACT_RUNNING;
                if (run_shadow != COUNT_MAX)
                    run_shadow++;
            end
            if (int'(run_shadow) >= lim && !alarm_shadow) begin
                alarm_shadow  = 1'b1;
                r.alarm_event = EVT_RAISE;
            end
        end
        phase_shadow++;
        if (phase_shadow >= dec)
            phase_shadow = 0;
        if (alarm_shadow) begin
            r.record_valid = 1'b1;
            r.record_byte  = BYTE_W'(mag / RECORD_DIV);
        end
        return r;
    endfunction

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // Offers one sample, after a random idle gap, and holds it until it is taken.
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] x,
                               input logic [SAMPLE_BITS-1:0] y,
                               input logic [SAMPLE_BITS-1:0] z);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_accel_x  <= x;
        i_accel_y  <= y;
        i_accel_z  <= z;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        predicted_words.push_back(classify_sample(x, y, z));
    endtask

    // Stops offering samples and waits until every predicted word has come out.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (predicted_words.size() != 0)
            @(posedge i_clk);
    endtask

    // APB write: a setup phase, an access phase, then the port is released.
    // Bits above the register width carry junk, which the block must ignore.
    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        logic [31:0] junk;
        logic [31:0] data;
        junk = $urandom();
        if (index == REG_WALK || index == REG_RUN)
            data = {junk[31:THRESH_W], value[THRESH_W-1:0]};
        else
            data = {junk[31:BYTE_W], value[BYTE_W-1:0]};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(4 * index);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_WALK:       cfg_shadow.walk_threshold = data[THRESH_W-1:0];
            REG_RUN:        cfg_shadow.run_threshold  = data[THRESH_W-1:0];
            REG_DECIMATION: cfg_shadow.decimation     = data[BYTE_W-1:0];
            REG_RUN_LIMIT:  cfg_shadow.run_limit      = data[BYTE_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic config_classifier(input logic [31:0] walk, input logic [31:0] run,
                                     input logic [31:0] dec, input logic [31:0] lim);
        write_register(REG_WALK, walk);
        write_register(REG_RUN, run);
        write_register(REG_DECIMATION, dec);
        write_register(REG_RUN_LIMIT, lim);
    endtask

    // One axis value at a motion level; the full level reaches the range ends now and then.
    function automatic logic [SAMPLE_BITS-1:0] axis_value(input int level);
        int amp;
        case (level)
            LVL_QUIET: amp = 200;
            LVL_WALK:  amp = 1200;
            LVL_RUN:   amp = 2500;
            default:   amp = 0;
        endcase
        if (level == LVL_FULL) begin
            if ($urandom_range(9) == 0)
                return $urandom_range(1) ? AXIS_MAX : AXIS_MIN;
            return SAMPLE_BITS'($urandom());
        end
        return SAMPLE_BITS'(int'($urandom_range(2 * amp)) - amp);
    endfunction

    // Sends bursts of samples at one motion level so that the filter settles and alarms
    // get raised and cancelled; about one sample in ten is full-range noise.
    task automatic send_motion(input int count);
        int level;
        int burst_len;
        int sent;
        sent = 0;
        while (sent < count) begin
            level     = $urandom_range(LVL_FULL);
            burst_len = $urandom_range(5, 40);
            for (int k = 0; k < burst_len && sent < count; k++) begin
                if ($urandom_range(9) == 0)
                    send_sample(axis_value(LVL_FULL), axis_value(LVL_FULL),
                                axis_value(LVL_FULL));
                else
                    send_sample(axis_value(level), axis_value(level), axis_value(level));
                sent++;
            end
        end
    endtask

    // Register defaults first, then a hand-made sequence: the range ends push the filter
    // into running and raise the alarm, and a run of zero samples lets it decay through
    // walking, which cancels the alarm, down to standing.
    task automatic test_directed_sequence();
        set_idling(37, 60);
        send_sample('0, '0, '0);
        send_sample(AXIS_MAX, AXIS_MAX, AXIS_MAX);
        send_sample(AXIS_MIN, AXIS_MIN, AXIS_MIN);
        wait_for_results();
        // The phase left over from decimation 10 wraps at once under decimation 1.
        config_classifier(3000000, 8000000, 1, 2);
        send_sample(AXIS_MIN, AXIS_MAX, AXIS_MIN);
        send_sample(AXIS_MAX, AXIS_MIN, AXIS_MAX);
        send_sample(13'd1, 13'h1FFF, '0);
        repeat (16) send_sample('0, '0, '0);
        wait_for_results();
    endtask

    // Zero thresholds make every class running, so the run counter climbs to its
    // saturation point and the largest run limit raises the alarm; a maximal run
    // threshold then turns the class to walking and cancels it.
    task automatic test_run_count_saturation();
        config_classifier(0, 0, 1, 255);
        send_motion(270);
        wait_for_results();
        config_classifier(0, 32'(THRESH_MAX), 1, 255);
        send_motion(10);
        wait_for_results();
    endtask

    task automatic random_config();
        logic [31:0] walk;
        logic [31:0] run;
        logic [31:0] dec;
        logic [31:0] lim;
        walk = $urandom_range(3000000, 100000);
        run  = $urandom_range(12000000, 2000000);
        if ($urandom_range(5) == 0)
            walk = run + $urandom_range(2000000);
        if ($urandom_range(7) == 0)
            walk = $urandom() & 32'(THRESH_MAX);
        if ($urandom_range(7) == 0)
            run = $urandom() & 32'(THRESH_MAX);
        dec = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(4, 1);
        lim = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(6, 1);
        config_classifier(walk, run, dec, lim);
    endtask

    // Three rounds of random traffic, each under its own idling pattern and with a few
    // register settings. The first settings of the first two rounds are the extremes:
    // all zero (zero decimation and zero run limit count as one) and all at maximum.
    task automatic test_random_traffic();
        for (int round = 0; round < 3; round++) begin
            case (round)
                0:       set_idling(37, 60);
                1:       set_idling(60, 37);
                default: set_idling(0, 0);
            endcase
            for (int ph = 0; ph < 4; ph++) begin
                if (round == 0 && ph == 0)
                    config_classifier(0, 0, 0, 0);
                else if (round == 1 && ph == 0)
                    config_classifier(32'(THRESH_MAX), 32'(THRESH_MAX), 32'hFF, 32'hFF);
                else
                    random_config();
                send_motion(55);
                wait_for_results();
            end
        end
    endtask

    // The output is held off for a long stretch while samples keep coming, so the
    // pipeline fills and the input stalls. After that the sender pauses until every
    // result is out before it starts again.
    task automatic test_backpressure();
        set_idling(0, 0);
        config_classifier(1000000, 4000000, 2, 1);
        stall_left = LONG_STALL;
        send_motion(40);
        wait_for_results();
        send_motion(20);
        wait_for_results();
    endtask

    initial begin
        reset_shadow();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_sequence();
        test_run_count_saturation();
        test_random_traffic();
        test_backpressure();

        // Give a stray word time to show up after the last expected one.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (predicted_words.size() != 0)
            report_mismatch("words never delivered", 0, predicted_words.size());

        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
